// ===== src/ccr_pkg.sv =====
package ccr_pkg;

    localparam int NUM_ROWS      = 8;
    localparam int ROW_IDX_W     = 3;
    localparam int LEN_W         = 4;
    localparam int POS_W         = 6;
    localparam int CODE_W        = 3;
    localparam int MAP_BYTE_W    = 8;
    localparam int MAP_W         = NUM_ROWS * MAP_BYTE_W;
    localparam int CODES_W       = NUM_ROWS * CODE_W;
    localparam int PACKED_W      = NUM_ROWS * LEN_W;
    localparam int ROW_WIDTH_DEF = 16;

    // remainder unit: 16-bit draw, divisor up to 16; quotient step, then remainder step
    localparam int DIV_W      = 5;
    localparam int DRAW_W     = 16;
    localparam int RECIP_W    = 32;
    localparam int REM_STEPS  = 2;
    localparam int STEP_CNT_W = $clog2(REM_STEPS);

    localparam int LCG_W = 32;
    localparam logic [LCG_W-1:0] LCG_MUL          = 32'h3c6e_f35f;
    localparam logic [LCG_W-1:0] LCG_ADD          = 32'h0019_660d;
    localparam logic [LCG_W-1:0] LCG_FIRST_INIT   = 32'd1234567;
    localparam logic [LCG_W-1:0] LCG_SECOND_INIT  = 32'd7654321;
    localparam logic [DIV_W-1:0] WANDER_SPAN      = 5'd3;
    // ceil(2^32 / 3)
    localparam logic [RECIP_W-1:0] WANDER_RECIP   = 32'h5555_5556;

    // APB register map, 64-bit registers at 8*i
    localparam int APB_DATA_W = 64;
    localparam int REG_IDX_W  = 2;
    localparam int PADDR_W    = REG_IDX_W + 3;
    localparam logic [REG_IDX_W-1:0] REG_TRIGGER_MAP  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_RULE_CODES   = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_RULE_TARGETS = 2'd2;
    localparam logic [CODES_W-1:0]   RULE_TARGETS_INIT = 24'hFAC688;

    typedef logic [LEN_W-1:0]            t_len;
    typedef logic signed [POS_W-1:0]     t_pos;
    typedef logic [ROW_IDX_W-1:0]        t_row;
    typedef logic [CODE_W-1:0]           t_code;
    typedef logic [MAP_BYTE_W-1:0]       t_map;

    localparam t_len RESET_LENGTHS [NUM_ROWS] = '{
        4'd3, 4'd1, 4'd2, 4'd2, 4'd3, 4'd3, 4'd5, 4'd7
    };

    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_SET  = 1'b1;

    localparam t_code RULE_NONE    = 3'd0;
    localparam t_code RULE_INC     = 3'd1;
    localparam t_code RULE_DEC     = 3'd2;
    localparam t_code RULE_MAX     = 3'd3;
    localparam t_code RULE_MIN     = 3'd4;
    localparam t_code RULE_RANDOM  = 3'd5;
    localparam t_code RULE_WANDER  = 3'd6;
    localparam t_code RULE_RESTORE = 3'd7;

    typedef logic [3:0] t_dp_op;
    localparam t_dp_op DP_NOP        = 4'd0;
    localparam t_dp_op DP_SET        = 4'd1;
    localparam t_dp_op DP_START      = 4'd2;
    localparam t_dp_op DP_DEC        = 4'd3;
    localparam t_dp_op DP_RULE       = 4'd4;
    localparam t_dp_op DP_LCG_FIRST  = 4'd5;
    localparam t_dp_op DP_LCG_SECOND = 4'd6;
    localparam t_dp_op DP_REM_LOAD   = 4'd7;
    localparam t_dp_op DP_REM_STEP   = 4'd8;
    localparam t_dp_op DP_RELOAD     = 4'd9;
    localparam t_dp_op DP_NEXT       = 4'd10;
    localparam t_dp_op DP_CLAMP      = 4'd11;

    typedef struct packed {
        t_dp_op op;
        t_row   sel;
        t_code  code;
        logic   emit;
        logic   emit_mask;
    } t_dp_cmd;

    typedef struct packed {
        logic  fire;
        t_code code;
        t_row  target;
        logic  stack_empty;
        logic  top_zero;
        t_row  low_row;
    } t_dp_sts;

    function automatic t_pos len_to_pos(input t_len len);
        return {{(POS_W-LEN_W){1'b0}}, len};
    endfunction

    function automatic t_row lowest_set(input t_map map);
        t_row idx;
        idx = '0;
        for (int i = MAP_BYTE_W - 1; i >= 0; i--) begin
            if (map[i]) begin
                idx = t_row'(i);
            end
        end
        return idx;
    endfunction

    function automatic logic pos_within_len(input logic [PACKED_W-1:0] pos,
                                            input logic [PACKED_W-1:0] len);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < NUM_ROWS; i++) begin
            if (pos[LEN_W*i +: LEN_W] > len[LEN_W*i +: LEN_W]) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

// ===== src/ccr_chan_if.sv =====
interface ccr_in_if;
    logic                 valid;
    logic                 ready;
    logic                 action;
    ccr_pkg::t_row        row;
    ccr_pkg::t_len        length;

    modport source (output valid, action, row, length, input ready);
    modport sink   (input valid, action, row, length, output ready);
endinterface

interface ccr_out_if;
    logic                              valid;
    logic                              ready;
    logic [ccr_pkg::NUM_ROWS-1:0]      fired_mask;
    logic [ccr_pkg::PACKED_W-1:0]      positions_packed;
    logic [ccr_pkg::PACKED_W-1:0]      lengths_packed;

    modport source (output valid, fired_mask, positions_packed, lengths_packed, input ready);
    modport sink   (input valid, fired_mask, positions_packed, lengths_packed, output ready);
endinterface

// ===== src/ccr_regs.sv =====
module ccr_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ccr_pkg::PADDR_W-1:0]         paddr,
    input  logic [ccr_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [ccr_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    output logic [ccr_pkg::MAP_W-1:0]           o_trigger_map,
    output logic [ccr_pkg::CODES_W-1:0]         o_rule_codes,
    output logic [ccr_pkg::CODES_W-1:0]         o_rule_targets
);

    logic [ccr_pkg::MAP_W-1:0]     r_trigger_map;
    logic [ccr_pkg::CODES_W-1:0]   r_rule_codes;
    logic [ccr_pkg::CODES_W-1:0]   r_rule_targets;
    logic [ccr_pkg::REG_IDX_W-1:0] w_idx;
    logic                          w_write;

    assign w_idx   = paddr[ccr_pkg::PADDR_W-1:3];
    assign w_write = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trigger_map  <= '0;
            r_rule_codes   <= '0;
            r_rule_targets <= ccr_pkg::RULE_TARGETS_INIT;
        end else if (w_write) begin
            case (w_idx)
                ccr_pkg::REG_TRIGGER_MAP:  r_trigger_map  <= pwdata[ccr_pkg::MAP_W-1:0];
                ccr_pkg::REG_RULE_CODES:   r_rule_codes   <= pwdata[ccr_pkg::CODES_W-1:0];
                ccr_pkg::REG_RULE_TARGETS: r_rule_targets <= pwdata[ccr_pkg::CODES_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            ccr_pkg::REG_TRIGGER_MAP:  prdata = ccr_pkg::APB_DATA_W'(r_trigger_map);
            ccr_pkg::REG_RULE_CODES:   prdata = ccr_pkg::APB_DATA_W'(r_rule_codes);
            ccr_pkg::REG_RULE_TARGETS: prdata = ccr_pkg::APB_DATA_W'(r_rule_targets);
            default:                   prdata = '0;
        endcase
    end

    assign o_trigger_map  = r_trigger_map;
    assign o_rule_codes   = r_rule_codes;
    assign o_rule_targets = r_rule_targets;

endmodule

// ===== src/ccr_dp.sv =====
module ccr_dp #(
    parameter int ROW_WIDTH = ccr_pkg::ROW_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ccr_pkg::t_dp_cmd                i_cmd,
    input  ccr_pkg::t_len                   i_set_length,
    input  logic [ccr_pkg::MAP_W-1:0]       i_trigger_map,
    input  logic [ccr_pkg::CODES_W-1:0]     i_rule_codes,
    input  logic [ccr_pkg::CODES_W-1:0]     i_rule_targets,
    output ccr_pkg::t_dp_sts                o_sts,
    output logic [ccr_pkg::NUM_ROWS-1:0]    o_fired_mask,
    output logic [ccr_pkg::PACKED_W-1:0]    o_positions_packed,
    output logic [ccr_pkg::PACKED_W-1:0]    o_lengths_packed
);

    localparam ccr_pkg::t_len            LEN_MAX = ccr_pkg::LEN_W'(ROW_WIDTH - 1);
    localparam logic [ccr_pkg::DIV_W-1:0] ROW_DIV = ccr_pkg::DIV_W'(ROW_WIDTH);
    // ceil(2^32 / ROW_WIDTH): exact quotient for any 16-bit draw
    localparam logic [ccr_pkg::RECIP_W-1:0] ROW_RECIP = ccr_pkg::RECIP_W'(
        ((64'd1 << ccr_pkg::RECIP_W) + 64'(ROW_WIDTH) - 64'd1) / 64'(ROW_WIDTH));

    ccr_pkg::t_pos  r_pos   [ccr_pkg::NUM_ROWS];
    ccr_pkg::t_len  r_len   [ccr_pkg::NUM_ROWS];
    ccr_pkg::t_len  r_saved [ccr_pkg::NUM_ROWS];
    logic [ccr_pkg::NUM_ROWS-1:0]  r_fired;
    logic [ccr_pkg::LCG_W-1:0]     r_lcg_first;
    logic [ccr_pkg::LCG_W-1:0]     r_lcg_second;

    // pending trigger maps of the rows still cascading, one frame per fired row
    ccr_pkg::t_map  r_stack [ccr_pkg::NUM_ROWS];
    logic [ccr_pkg::ROW_IDX_W:0]   r_sp;

    logic [ccr_pkg::DRAW_W-1:0]    r_dividend;
    logic [ccr_pkg::DIV_W-1:0]     r_rem;
    logic [ccr_pkg::DIV_W-1:0]     r_divisor;
    logic [ccr_pkg::RECIP_W-1:0]   r_recip;
    logic [ccr_pkg::DRAW_W-1:0]    r_quot;

    ccr_pkg::t_map  w_trig    [ccr_pkg::NUM_ROWS];
    ccr_pkg::t_code w_codes   [ccr_pkg::NUM_ROWS];
    ccr_pkg::t_row  w_targets [ccr_pkg::NUM_ROWS];
    ccr_pkg::t_pos  w_clamped [ccr_pkg::NUM_ROWS];

    ccr_pkg::t_pos  w_sel_pos;
    ccr_pkg::t_len  w_sel_len;
    ccr_pkg::t_pos  w_pos_dec;
    ccr_pkg::t_pos  w_reload_pos;
    ccr_pkg::t_len  w_rule_len;
    ccr_pkg::t_pos  w_rule_pos;
    ccr_pkg::t_len  w_set_len;
    logic [ccr_pkg::DIV_W-1:0]     w_wsum;
    logic [ccr_pkg::DIV_W-1:0]     w_wval;
    logic [ccr_pkg::ROW_IDX_W-1:0] w_top_idx;
    ccr_pkg::t_map  w_top;
    logic [ccr_pkg::DRAW_W+ccr_pkg::RECIP_W-1:0] w_prod;
    logic [ccr_pkg::DRAW_W+ccr_pkg::DIV_W-1:0]   w_qd;
    logic [ccr_pkg::DRAW_W-1:0]    w_rem_full;
    logic [ccr_pkg::DRAW_W-1:0]    n_quot;
    logic [ccr_pkg::DIV_W-1:0]     n_rem;

    always_comb begin
        for (int i = 0; i < ccr_pkg::NUM_ROWS; i++) begin
            w_trig[i]    = i_trigger_map[ccr_pkg::MAP_BYTE_W*i +: ccr_pkg::MAP_BYTE_W];
            w_codes[i]   = i_rule_codes[ccr_pkg::CODE_W*i +: ccr_pkg::CODE_W];
            w_targets[i] = i_rule_targets[ccr_pkg::CODE_W*i +: ccr_pkg::CODE_W];
        end
    end

    assign w_sel_pos    = r_pos[i_cmd.sel];
    assign w_sel_len    = r_len[i_cmd.sel];
    assign w_pos_dec    = w_sel_pos - ccr_pkg::t_pos'(1);
    assign w_reload_pos = w_sel_pos + ccr_pkg::len_to_pos(w_sel_len) + ccr_pkg::t_pos'(1);
    assign w_set_len    = (i_set_length > LEN_MAX) ? LEN_MAX : i_set_length;

    assign w_top_idx = r_sp[ccr_pkg::ROW_IDX_W-1:0] - 1'b1;
    assign w_top     = r_stack[w_top_idx];

    // rule on the target row; remainder holds the draw reduced for random/wander
    assign w_wsum = ccr_pkg::DIV_W'(w_sel_len) + r_rem;
    assign w_wval = w_wsum - 1'b1;

    always_comb begin
        w_rule_len = w_sel_len;
        w_rule_pos = w_sel_pos;
        case (i_cmd.code)
            ccr_pkg::RULE_INC: begin
                if (w_sel_len < LEN_MAX) begin
                    w_rule_len = w_sel_len + 1'b1;
                    w_rule_pos = ccr_pkg::len_to_pos(w_rule_len);
                end
            end
            ccr_pkg::RULE_DEC: begin
                if (w_sel_len != '0) begin
                    w_rule_len = w_sel_len - 1'b1;
                    w_rule_pos = ccr_pkg::len_to_pos(w_rule_len);
                end
            end
            ccr_pkg::RULE_MAX: begin
                w_rule_len = LEN_MAX;
                w_rule_pos = ccr_pkg::len_to_pos(LEN_MAX);
            end
            ccr_pkg::RULE_MIN: begin
                w_rule_len = '0;
                w_rule_pos = '0;
            end
            ccr_pkg::RULE_RANDOM: begin
                w_rule_len = r_rem[ccr_pkg::LEN_W-1:0];
                w_rule_pos = ccr_pkg::len_to_pos(w_rule_len);
            end
            ccr_pkg::RULE_WANDER: begin
                if (w_wsum == '0) begin
                    w_rule_len = '0;
                end else if (w_wval > ccr_pkg::DIV_W'(LEN_MAX)) begin
                    w_rule_len = LEN_MAX;
                end else begin
                    w_rule_len = w_wval[ccr_pkg::LEN_W-1:0];
                end
                w_rule_pos = ccr_pkg::len_to_pos(w_rule_len);
            end
            ccr_pkg::RULE_RESTORE: begin
                w_rule_len = r_saved[i_cmd.sel];
            end
            default: ;
        endcase
    end

    // reciprocal remainder: quotient from the high product bits, then one subtract
    assign w_prod     = r_dividend * r_recip;
    assign n_quot     = w_prod[ccr_pkg::DRAW_W+ccr_pkg::RECIP_W-1 -: ccr_pkg::DRAW_W];
    assign w_qd       = r_quot * r_divisor;
    assign w_rem_full = r_dividend - w_qd[ccr_pkg::DRAW_W-1:0];
    assign n_rem      = w_rem_full[ccr_pkg::DIV_W-1:0];

    always_comb begin
        for (int i = 0; i < ccr_pkg::NUM_ROWS; i++) begin
            if (r_pos[i] < 0) begin
                w_clamped[i] = '0;
            end else if (r_pos[i] > ccr_pkg::len_to_pos(r_len[i])) begin
                w_clamped[i] = ccr_pkg::len_to_pos(r_len[i]);
            end else begin
                w_clamped[i] = r_pos[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ccr_pkg::NUM_ROWS; i++) begin
                r_pos[i]   <= ccr_pkg::len_to_pos(ccr_pkg::RESET_LENGTHS[i]);
                r_len[i]   <= ccr_pkg::RESET_LENGTHS[i];
                r_saved[i] <= ccr_pkg::RESET_LENGTHS[i];
            end
            r_fired      <= '0;
            r_lcg_first  <= ccr_pkg::LCG_FIRST_INIT;
            r_lcg_second <= ccr_pkg::LCG_SECOND_INIT;
            r_sp         <= '0;
        end else begin
            case (i_cmd.op)
                ccr_pkg::DP_SET: begin
                    r_len[i_cmd.sel]   <= w_set_len;
                    r_saved[i_cmd.sel] <= w_set_len;
                    r_pos[i_cmd.sel]   <= ccr_pkg::len_to_pos(w_set_len);
                end
                ccr_pkg::DP_START: begin
                    r_fired <= '0;
                    r_sp    <= '0;
                end
                ccr_pkg::DP_DEC: begin
                    r_pos[i_cmd.sel] <= w_pos_dec;
                    if (o_sts.fire) begin
                        r_fired[i_cmd.sel] <= 1'b1;
                    end
                end
                ccr_pkg::DP_RULE: begin
                    r_len[i_cmd.sel] <= w_rule_len;
                    r_pos[i_cmd.sel] <= w_rule_pos;
                end
                ccr_pkg::DP_LCG_FIRST: begin
                    r_lcg_first <= r_lcg_first * ccr_pkg::LCG_MUL + ccr_pkg::LCG_ADD;
                end
                ccr_pkg::DP_LCG_SECOND: begin
                    r_lcg_second <= r_lcg_second * ccr_pkg::LCG_MUL + ccr_pkg::LCG_ADD;
                end
                ccr_pkg::DP_RELOAD: begin
                    r_pos[i_cmd.sel] <= w_reload_pos;
                    r_sp             <= r_sp + 1'b1;
                end
                ccr_pkg::DP_NEXT: begin
                    if (w_top == '0) begin
                        r_sp <= r_sp - 1'b1;
                    end
                end
                ccr_pkg::DP_CLAMP: begin
                    for (int i = 0; i < ccr_pkg::NUM_ROWS; i++) begin
                        r_pos[i] <= w_clamped[i];
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            ccr_pkg::DP_RELOAD: begin
                r_stack[r_sp[ccr_pkg::ROW_IDX_W-1:0]] <= w_trig[i_cmd.sel];
            end
            ccr_pkg::DP_NEXT: begin
                // drop the lowest pending row of the top frame
                r_stack[w_top_idx] <= w_top & (w_top - 1'b1);
            end
            ccr_pkg::DP_REM_LOAD: begin
                r_dividend <= r_lcg_first[ccr_pkg::LCG_W-1 -: ccr_pkg::DRAW_W]
                            | r_lcg_second[ccr_pkg::LCG_W-1 -: ccr_pkg::DRAW_W];
                r_rem      <= '0;
                r_divisor  <= (i_cmd.code == ccr_pkg::RULE_RANDOM) ? ROW_DIV
                                                                   : ccr_pkg::WANDER_SPAN;
                r_recip    <= (i_cmd.code == ccr_pkg::RULE_RANDOM) ? ROW_RECIP
                                                                   : ccr_pkg::WANDER_RECIP;
            end
            ccr_pkg::DP_REM_STEP: begin
                // first step settles the quotient, second the remainder
                r_quot <= n_quot;
                r_rem  <= n_rem;
            end
            default: ;
        endcase
    end

    assign o_sts.fire        = w_pos_dec[ccr_pkg::POS_W-1] && !r_fired[i_cmd.sel];
    assign o_sts.code        = w_codes[i_cmd.sel];
    assign o_sts.target      = w_targets[i_cmd.sel];
    assign o_sts.stack_empty = (r_sp == '0);
    assign o_sts.top_zero    = (w_top == '0);
    assign o_sts.low_row     = ccr_pkg::lowest_set(w_top);

    always_comb begin
        for (int i = 0; i < ccr_pkg::NUM_ROWS; i++) begin
            o_positions_packed[ccr_pkg::LEN_W*i +: ccr_pkg::LEN_W] =
                r_pos[i][ccr_pkg::LEN_W-1:0];
            o_lengths_packed[ccr_pkg::LEN_W*i +: ccr_pkg::LEN_W] = r_len[i];
        end
    end

    assign o_fired_mask = r_fired;

endmodule

// ===== src/ccr_ctrl.sv =====
module ccr_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_action,
    input  ccr_pkg::t_row      i_in_row,
    input  logic               i_out_free,
    input  ccr_pkg::t_dp_sts   i_sts,
    output logic               o_in_ready,
    output ccr_pkg::t_dp_cmd   o_cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DEC      = 4'd1;
    localparam logic [3:0] S_LCG1     = 4'd2;
    localparam logic [3:0] S_LCG2     = 4'd3;
    localparam logic [3:0] S_REM_LOAD = 4'd4;
    localparam logic [3:0] S_REM_STEP = 4'd5;
    localparam logic [3:0] S_RULE     = 4'd6;
    localparam logic [3:0] S_RELOAD   = 4'd7;
    localparam logic [3:0] S_NEXT     = 4'd8;
    localparam logic [3:0] S_CLAMP    = 4'd9;
    localparam logic [3:0] S_EMIT     = 4'd10;

    logic [3:0]                         r_state, n_state;
    ccr_pkg::t_row                      r_cur,   n_cur;
    ccr_pkg::t_row                      r_tgt,   n_tgt;
    ccr_pkg::t_code                     r_code,  n_code;
    logic [ccr_pkg::STEP_CNT_W-1:0]     r_step,  n_step;
    logic                               r_tick,  n_tick;

    always_comb begin
        n_state = r_state;
        n_cur   = r_cur;
        n_tgt   = r_tgt;
        n_code  = r_code;
        n_step  = r_step;
        n_tick  = r_tick;

        o_in_ready      = 1'b0;
        o_cmd.op        = ccr_pkg::DP_NOP;
        o_cmd.sel       = r_cur;
        o_cmd.code      = r_code;
        o_cmd.emit      = 1'b0;
        o_cmd.emit_mask = r_tick;

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_action == ccr_pkg::ACT_SET) begin
                        o_cmd.op  = ccr_pkg::DP_SET;
                        o_cmd.sel = i_in_row;
                        n_tick    = 1'b0;
                        n_state   = S_EMIT;
                    end else begin
                        o_cmd.op = ccr_pkg::DP_START;
                        n_cur    = '0;
                        n_tick   = 1'b1;
                        n_state  = S_DEC;
                    end
                end
            end
            S_DEC: begin
                o_cmd.op = ccr_pkg::DP_DEC;
                if (i_sts.fire) begin
                    n_tgt  = i_sts.target;
                    n_code = i_sts.code;
                    case (i_sts.code)
                        ccr_pkg::RULE_NONE:   n_state = S_RELOAD;
                        ccr_pkg::RULE_RANDOM: n_state = S_LCG1;
                        ccr_pkg::RULE_WANDER: n_state = S_LCG1;
                        default:              n_state = S_RULE;
                    endcase
                end else begin
                    n_state = S_NEXT;
                end
            end
            S_LCG1: begin
                o_cmd.op = ccr_pkg::DP_LCG_FIRST;
                n_state  = S_LCG2;
            end
            S_LCG2: begin
                o_cmd.op = ccr_pkg::DP_LCG_SECOND;
                n_state  = S_REM_LOAD;
            end
            S_REM_LOAD: begin
                o_cmd.op = ccr_pkg::DP_REM_LOAD;
                n_step   = '0;
                n_state  = S_REM_STEP;
            end
            S_REM_STEP: begin
                o_cmd.op = ccr_pkg::DP_REM_STEP;
                n_step   = r_step + 1'b1;
                if (r_step == ccr_pkg::STEP_CNT_W'(ccr_pkg::REM_STEPS - 1)) begin
                    n_state = S_RULE;
                end
            end
            S_RULE: begin
                o_cmd.op  = ccr_pkg::DP_RULE;
                o_cmd.sel = r_tgt;
                n_state   = S_RELOAD;
            end
            S_RELOAD: begin
                o_cmd.op = ccr_pkg::DP_RELOAD;
                n_state  = S_NEXT;
            end
            S_NEXT: begin
                if (i_sts.stack_empty) begin
                    n_state = S_CLAMP;
                end else begin
                    o_cmd.op = ccr_pkg::DP_NEXT;
                    if (!i_sts.top_zero) begin
                        n_cur   = i_sts.low_row;
                        n_state = S_DEC;
                    end
                end
            end
            S_CLAMP: begin
                o_cmd.op = ccr_pkg::DP_CLAMP;
                n_state  = S_EMIT;
            end
            S_EMIT: begin
                if (i_out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cur   <= '0;
            r_tgt   <= '0;
            r_code  <= ccr_pkg::RULE_NONE;
            r_step  <= '0;
            r_tick  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cur   <= n_cur;
            r_tgt   <= n_tgt;
            r_code  <= n_code;
            r_step  <= n_step;
            r_tick  <= n_tick;
        end
    end

endmodule

// ===== src/cascading_countdown_rows_unit.sv =====
// Set word: accepted, then loaded into the output register once that register is free.
// Tick word: the cascade walk grows with the row decrements (up to 65), the rows
//   fired and the fired rows with a random or wander rule.
// One word in flight; the next is taken once the result sits in the output register.
// Reset (i_rst_n low, synchronous): rows back to lengths 3,1,2,2,3,3,5,7, generators
//   reseeded, registers to defaults, output empty.
module cascading_countdown_rows_unit #(
    parameter int ROW_WIDTH = ccr_pkg::ROW_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    ccr_in_if.sink                          i_in_ch,
    ccr_out_if.source                       o_out_ch,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ccr_pkg::PADDR_W-1:0]     paddr,
    input  logic [ccr_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [ccr_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    // configuration registers
    logic [ccr_pkg::MAP_W-1:0]    w_trigger_map;
    logic [ccr_pkg::CODES_W-1:0]  w_rule_codes;
    logic [ccr_pkg::CODES_W-1:0]  w_rule_targets;

    // controller <-> datapath
    ccr_pkg::t_dp_cmd             w_cmd;
    ccr_pkg::t_dp_sts             w_sts;
    logic                         w_out_free;

    // datapath views of the row state
    logic [ccr_pkg::NUM_ROWS-1:0] w_fired_mask;
    logic [ccr_pkg::PACKED_W-1:0] w_pos_packed;
    logic [ccr_pkg::PACKED_W-1:0] w_len_packed;

    // output register: holds a finished word while the next one is taken in
    logic                         r_out_valid;
    logic [ccr_pkg::NUM_ROWS-1:0] r_out_mask;
    logic [ccr_pkg::PACKED_W-1:0] r_out_pos;
    logic [ccr_pkg::PACKED_W-1:0] r_out_len;

    ccr_regs u_regs (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_trigger_map  (w_trigger_map),
        .o_rule_codes   (w_rule_codes),
        .o_rule_targets (w_rule_targets)
    );

    // sequencer: walks the cascade depth first, one decrement per visit
    ccr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_ch.valid),
        .i_action   (i_in_ch.action),
        .i_in_row   (i_in_ch.row),
        .i_out_free (w_out_free),
        .i_sts      (w_sts),
        .o_in_ready (i_in_ch.ready),
        .o_cmd      (w_cmd)
    );

    // row state, fired marks, generators, remainder unit and cascade stack
    ccr_dp #(
        .ROW_WIDTH (ROW_WIDTH)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .i_set_length       (i_in_ch.length),
        .i_trigger_map      (w_trigger_map),
        .i_rule_codes       (w_rule_codes),
        .i_rule_targets     (w_rule_targets),
        .o_sts              (w_sts),
        .o_fired_mask       (w_fired_mask),
        .o_positions_packed (w_pos_packed),
        .o_lengths_packed   (w_len_packed)
    );

    // free when empty or being emptied this cycle
    assign w_out_free = !r_out_valid || o_out_ch.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // set words report no firing
    always_ff @(posedge i_clk) begin
        if (w_cmd.emit) begin
            r_out_mask <= w_cmd.emit_mask ? w_fired_mask : '0;
            r_out_pos  <= w_pos_packed;
            r_out_len  <= w_len_packed;
        end
    end

    assign o_out_ch.valid            = r_out_valid;
    assign o_out_ch.fired_mask       = r_out_mask;
    assign o_out_ch.positions_packed = r_out_pos;
    assign o_out_ch.lengths_packed   = r_out_len;

    // the controller never loads the output register over an untaken word
    a_emit_into_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> w_out_free)
        else $error("result loaded over a word not yet taken");

    // a set word carries an empty fired mask
    a_set_mask_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.emit && !w_cmd.emit_mask) |=> (r_out_mask == '0))
        else $error("set word reports fired rows");

    // every reported position lies within its row length
    a_pos_within_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ccr_pkg::pos_within_len(r_out_pos, r_out_len))
        else $error("reported position beyond row length");

    // a word taken in always keeps the unit busy for the following cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_ch.valid && i_in_ch.ready) |=> !i_in_ch.ready)
        else $error("input taken again straight after a word");

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
    import ccr_pkg::*;

    localparam int ROW_W        = ROW_WIDTH_DEF;
    localparam int CLK_HALF     = 4;
    // drain window after the last word, meant to cover the worst tick walk
    localparam int DRAIN_CYCLES = 250;
    localparam int RUN_LIMIT    = 8_000_000;
    localparam logic [MAP_W-1:0]   MAP_ALL   = '1;
    localparam logic [MAP_W-1:0]   MAP_NONE  = '0;
    localparam logic [CODES_W-1:0] FIELD_ALL = '1;
    localparam logic [CODES_W-1:0] FIELD_NONE = '0;

    // what one result word carries
    typedef struct packed {
        logic [NUM_ROWS-1:0] fired_mask;
        logic [PACKED_W-1:0] positions;
        logic [PACKED_W-1:0] lengths;
    } t_rows_view;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_W-1:0]    paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    ccr_in_if  in_ch ();
    ccr_out_if out_ch ();

    cascading_countdown_rows_unit #(
        .ROW_WIDTH (ROW_W)
    ) i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (in_ch),
        .o_out_ch (out_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // ------------------------------------------------------------------
    // Row model: own copy of row state, generators and register contents
    // ------------------------------------------------------------------
    t_pos                row_pos   [NUM_ROWS];
    t_len                row_len   [NUM_ROWS];
    t_len                row_saved [NUM_ROWS];
    logic                row_fired [NUM_ROWS];
    logic [LCG_W-1:0]    gen_a;
    logic [LCG_W-1:0]    gen_b;
    logic [MAP_W-1:0]    cfg_map;
    logic [CODES_W-1:0]  cfg_codes;
    logic [CODES_W-1:0]  cfg_targets;

    t_rows_view pending_views [$];   // predicted words, oldest first
    int         mismatches     = 0;
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    int         hold_left      = 0;  // long receiver hold-off, counted down by the ready driver

    function automatic void reset_rows();
        for (int i = 0; i < NUM_ROWS; i++) begin
            row_len[i]   = RESET_LENGTHS[i];
            row_saved[i] = RESET_LENGTHS[i];
            row_pos[i]   = t_pos'(int'(RESET_LENGTHS[i]));
            row_fired[i] = 1'b0;
        end
        gen_a       = LCG_FIRST_INIT;
        gen_b       = LCG_SECOND_INIT;
        cfg_map     = MAP_NONE;
        cfg_codes   = FIELD_NONE;
        cfg_targets = RULE_TARGETS_INIT;
    endfunction

    // both generators step on every draw; draw is the OR of their top halves
    function automatic logic [DRAW_W-1:0] next_draw();
        gen_a = gen_a * LCG_MUL + LCG_ADD;
        gen_b = gen_b * LCG_MUL + LCG_ADD;
        return gen_a[LCG_W-1 -: DRAW_W] | gen_b[LCG_W-1 -: DRAW_W];
    endfunction

    function automatic void apply_rule(input t_code code, input t_row t);
        logic [DRAW_W-1:0] d;
        int                v;
        case (code)
            RULE_INC: begin
                if (int'(row_len[t]) < ROW_W - 1) begin
                    row_len[t] = row_len[t] + 1'b1;
                    row_pos[t] = t_pos'(int'(row_len[t]));
                end
            end
            RULE_DEC: begin
                if (row_len[t] != '0) begin
                    row_len[t] = row_len[t] - 1'b1;
                    row_pos[t] = t_pos'(int'(row_len[t]));
                end
            end
            RULE_MAX: begin
                row_len[t] = t_len'(ROW_W - 1);
                row_pos[t] = t_pos'(ROW_W - 1);
            end
            RULE_MIN: begin
                row_len[t] = '0;
                row_pos[t] = '0;
            end
            RULE_RANDOM: begin
                d          = next_draw();
                row_len[t] = t_len'(int'(d) % ROW_W);
                row_pos[t] = t_pos'(int'(row_len[t]));
            end
            RULE_WANDER: begin
                d = next_draw();
                v = int'(row_len[t]) + (int'(d) % 3) - 1;
                if (v < 0) begin
                    v = 0;
                end else if (v > ROW_W - 1) begin
                    v = ROW_W - 1;
                end
                row_len[t] = t_len'(v);
                row_pos[t] = t_pos'(v);
            end
            RULE_RESTORE: begin
                row_len[t] = row_saved[t];   // position left alone
            end
            default: begin
            end
        endcase
    endfunction

    // one decrement, depth first through the trigger map
    function automatic void countdown(input int n);
        t_map hits;
        row_pos[n] = row_pos[n] - 1'b1;
        if (row_pos[n] < 0 && !row_fired[n]) begin
            row_fired[n] = 1'b1;
            apply_rule(cfg_codes[CODE_W*n +: CODE_W], cfg_targets[CODE_W*n +: CODE_W]);
            row_pos[n] = t_pos'(int'(row_pos[n]) + int'(row_len[n]) + 1);
            hits = cfg_map[MAP_BYTE_W*n +: MAP_BYTE_W];
            for (int m = 0; m < NUM_ROWS; m++) begin
                if (hits[m]) begin
                    countdown(m);
                end
            end
        end
    endfunction

    function automatic t_rows_view advance_rows(input logic act, input t_row r, input t_len l);
        t_rows_view view;
        t_len       lv;
        view = '0;
        if (act == ACT_TICK) begin
            for (int i = 0; i < NUM_ROWS; i++) begin
                row_fired[i] = 1'b0;
            end
            countdown(0);
            for (int i = 0; i < NUM_ROWS; i++) begin
                if (row_pos[i] < 0) begin
                    row_pos[i] = '0;
                end else if (int'(row_pos[i]) > int'(row_len[i])) begin
                    row_pos[i] = t_pos'(int'(row_len[i]));
                end
                view.fired_mask[i] = row_fired[i];
            end
        end else begin
            // set word: marks and generators untouched
            lv = l;
            if (int'(lv) > ROW_W - 1) begin
                lv = t_len'(ROW_W - 1);
            end
            row_len[r]   = lv;
            row_saved[r] = lv;
            row_pos[r]   = t_pos'(int'(lv));
        end
        for (int i = 0; i < NUM_ROWS; i++) begin
            view.positions[LEN_W*i +: LEN_W] = row_pos[i][LEN_W-1:0];
            view.lengths[LEN_W*i +: LEN_W]   = row_len[i];
        end
        return view;
    endfunction

    // ------------------------------------------------------------------
    // Clock, limit, receiver
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    initial begin
        #RUN_LIMIT;
        $display("tb_top: FAIL");
        $finish;
    end

    // ready: random stalls per phase, or held low while a hold-off is counting
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic flag_mismatch(input string what);
        $display("%0t mismatch: %s", $time, what);
        mismatches++;
    endtask

    // every accepted result word against the oldest prediction
    always @(posedge i_clk) begin
        t_rows_view want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_views.size() == 0) begin
                flag_mismatch("result word with nothing expected");
            end else begin
                want = pending_views.pop_front();
                if (out_ch.fired_mask !== want.fired_mask) begin
                    flag_mismatch($sformatf("fired_mask %h, want %h",
                                            out_ch.fired_mask, want.fired_mask));
                end
                if (out_ch.positions_packed !== want.positions) begin
                    flag_mismatch($sformatf("positions_packed %h, want %h",
                                            out_ch.positions_packed, want.positions));
                end
                if (out_ch.lengths_packed !== want.lengths) begin
                    flag_mismatch($sformatf("lengths_packed %h, want %h",
                                            out_ch.lengths_packed, want.lengths));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    // valid is left high on return; the next call redrives it, or wait_drained drops it, in the same step
    task automatic send_word(input logic act, input t_row r, input t_len l);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.action <= act;
        in_ch.row    <= r;
        in_ch.length <= l;
        do begin
            @(posedge i_clk);
        end while (!(in_ch.valid && in_ch.ready));
        pending_views.push_back(advance_rows(act, r, l));
    endtask

    task automatic send_tick();
        // row and length are don't-care on a tick, so toggle them anyway
        send_word(ACT_TICK, t_row'($urandom), t_len'($urandom));
    endtask

    task automatic send_random_word();
        if ($urandom_range(99) < 80) begin
            send_tick();
        end else if ($urandom_range(3) == 0) begin
            send_word(ACT_SET, t_row'($urandom), t_len'($urandom_range(15)));
        end else begin
            // short rows fire often and keep the cascade busy
            send_word(ACT_SET, t_row'($urandom), t_len'($urandom_range(3)));
        end
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (pending_views.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // ------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(idx) << 3;
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_TRIGGER_MAP:  cfg_map     = val[MAP_W-1:0];
            REG_RULE_CODES:   cfg_codes   = val[CODES_W-1:0];
            REG_RULE_TARGETS: cfg_targets = val[CODES_W-1:0];
            default: begin
            end
        endcase
    endtask

    // only while idle: every word back first
    task automatic load_config(input logic [MAP_W-1:0] m, input logic [CODES_W-1:0] codes,
                               input logic [CODES_W-1:0] targets);
        wait_drained();
        repeat (4) @(posedge i_clk);
        write_reg(REG_TRIGGER_MAP, APB_DATA_W'(m));
        write_reg(REG_RULE_CODES, APB_DATA_W'(codes));
        write_reg(REG_RULE_TARGETS, APB_DATA_W'(targets));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // reset rows, no rules, empty map: only row 0 counts down
    task automatic test_reset_ticks();
        repeat (4) send_tick();
    endtask

    task automatic test_set_extremes();
        send_word(ACT_SET, t_row'(0), t_len'(0));
        send_word(ACT_SET, t_row'(NUM_ROWS - 1), t_len'(ROW_W - 1));
        send_tick();
        send_tick();
        send_word(ACT_SET, t_row'(3), t_len'(ROW_W - 1));
        send_word(ACT_SET, t_row'(0), t_len'(ROW_W - 1));
        send_tick();
    endtask

    // row n carries rule n, all rows trigger all rows, each row targets itself
    task automatic test_each_rule();
        load_config(MAP_ALL,
                    {RULE_RESTORE, RULE_WANDER, RULE_RANDOM, RULE_MIN,
                     RULE_MAX, RULE_DEC, RULE_INC, RULE_NONE},
                    RULE_TARGETS_INIT);
        send_word(ACT_SET, t_row'(0), t_len'(0));
        repeat (3) send_tick();
        // a set between random draws must leave the generators alone
        send_word(ACT_SET, t_row'(5), t_len'(9));
        repeat (3) send_tick();
    endtask

    // row 0 triggers only itself: repeated decrement after firing, then clamp
    task automatic test_self_trigger();
        load_config(MAP_W'(1), FIELD_NONE, RULE_TARGETS_INIT);
        repeat (3) send_tick();
    endtask

    // long receiver hold-off with the sender pushing, then a full pause
    task automatic test_backpressure();
        load_config({$urandom, $urandom}, CODES_W'($urandom), CODES_W'($urandom));
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 150;
        repeat (16) send_random_word();
        wait_drained();
        repeat (10) send_random_word();
        wait_drained();
    endtask

    // one idling setting; an extreme register set, then two random ones
    task automatic test_random_phase(input int send_pct, input int recv_pct, input int extreme,
                                     input int words);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        case (extreme)
            0: load_config(MAP_ALL, FIELD_ALL, FIELD_NONE);
            1: load_config(MAP_NONE, FIELD_NONE, FIELD_ALL);
            2: load_config(MAP_ALL, FIELD_NONE, RULE_TARGETS_INIT);
            default: load_config(MAP_ALL, FIELD_ALL, FIELD_ALL);
        endcase
        repeat (words / 3) send_random_word();
        // sparse map
        load_config({$urandom, $urandom} & {$urandom, $urandom},
                    CODES_W'($urandom), CODES_W'($urandom));
        repeat (words / 3) send_random_word();
        // dense map, long cascades
        load_config({$urandom, $urandom}, CODES_W'($urandom), CODES_W'($urandom));
        repeat (words / 3) send_random_word();
    endtask

    initial begin
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.action = ACT_TICK;
        in_ch.row    = '0;
        in_ch.length = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        reset_rows();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_ticks();
        test_set_extremes();
        test_each_rule();
        test_self_trigger();
        test_backpressure();
        test_random_phase(0, 0, 0, 108);
        test_random_phase(50, 0, 1, 108);
        test_random_phase(0, 50, 2, 108);
        test_random_phase(19, 19, 3, 108);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_views.size() != 0) begin
            flag_mismatch($sformatf("%0d words never came back", pending_views.size()));
        end
        if (mismatches == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
